@@ hdl/tbpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tbpt_pkg
// Widths, codes and shared types of the task burst penalty tracker.
// ----------------------------------------------------------------------------
package tbpt_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned DeltaW   = 64;
  localparam int unsigned ScoreW   = 14;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned SmoothW  = 2;
  localparam int unsigned OffsetW  = 7;
  localparam int unsigned ScaleW   = 12;
  localparam int unsigned LeadW    = 7;
  localparam int unsigned FracW    = 8;
  localparam int unsigned LogW     = LeadW + FracW;
  localparam int unsigned ProdW    = LogW + ScaleW;
  localparam int unsigned ScaleShift = 10;

  localparam logic [OpW-1:0] OP_RUN     = 2'd0;
  localparam logic [OpW-1:0] OP_RESTART = 2'd1;
  localparam logic [OpW-1:0] OP_FORK    = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SMOOTH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SCALE  = 2'd3;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_RUN,
    KIND_RESTART,
    KIND_FORK
  } kind_e;

  typedef struct packed {
    logic               enable;
    logic [SmoothW-1:0] smooth;
    logic [OffsetW-1:0] offset;
    logic [ScaleW-1:0]  scale;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic              kthread;
    logic [ScoreW-1:0] inherit;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic [DeltaW-1:0] delta;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

@@ hdl/tbpt_in_if.sv @@
// ----------------------------------------------------------------------------
// tbpt_in_if
// Input channel: accounting events with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbpt_in_if;
  logic                         valid;
  logic                         ready;
  logic [tbpt_pkg::OpW-1:0]     op;
  logic [tbpt_pkg::DeltaW-1:0]  delta_ns;
  logic                         is_kernel_thread;
  logic [tbpt_pkg::ScoreW-1:0]  inherited_penalty;

  modport source (
    output valid, op, delta_ns, is_kernel_thread, inherited_penalty,
    input  ready
  );
  modport sink (
    input  valid, op, delta_ns, is_kernel_thread, inherited_penalty,
    output ready
  );
endinterface

@@ hdl/tbpt_out_if.sv @@
// ----------------------------------------------------------------------------
// tbpt_out_if
// Output channel: penalties after each event, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbpt_out_if;
  logic                         valid;
  logic                         ready;
  logic [tbpt_pkg::ScoreW-1:0]  penalty;
  logic [tbpt_pkg::ScoreW-1:0]  current_penalty;
  logic [tbpt_pkg::ScoreW-1:0]  previous_penalty;

  modport source (
    output valid, penalty, current_penalty, previous_penalty,
    input  ready
  );
  modport sink (
    input  valid, penalty, current_penalty, previous_penalty,
    output ready
  );
endinterface

@@ hdl/tbpt_front.sv @@
// ----------------------------------------------------------------------------
// tbpt_front
// Accepts events, decodes them into commands and saturates inherited penalty.
// ----------------------------------------------------------------------------
module tbpt_front #(
  parameter int unsigned MaxPenalty = 10239
) (
  tbpt_in_if.sink               in_i,
  input  tbpt_pkg::cfg_t        cfg_i,
  input  logic                  full_i,
  output tbpt_pkg::push_t       push_o
);

  localparam logic [tbpt_pkg::ScoreW-1:0] MaxPen = tbpt_pkg::ScoreW'(MaxPenalty);

  tbpt_pkg::kind_e               kind;
  logic [tbpt_pkg::ScoreW-1:0]   inherit_sat;

  always_comb begin
    kind = tbpt_pkg::KIND_NOP;
    if (cfg_i.enable) begin
      case (in_i.op)
        tbpt_pkg::OP_RUN:     kind = tbpt_pkg::KIND_RUN;
        tbpt_pkg::OP_RESTART: kind = tbpt_pkg::KIND_RESTART;
        tbpt_pkg::OP_FORK: begin
          if (!in_i.is_kernel_thread) kind = tbpt_pkg::KIND_FORK;
        end
        default:              kind = tbpt_pkg::KIND_NOP;
      endcase
    end
  end

  assign inherit_sat = (in_i.inherited_penalty > MaxPen) ? MaxPen : in_i.inherited_penalty;

  assign in_i.ready              = !full_i;
  assign push_o.push             = in_i.valid && !full_i;
  assign push_o.cmd.tag.kind     = kind;
  assign push_o.cmd.tag.kthread  = in_i.is_kernel_thread;
  assign push_o.cmd.tag.inherit  = inherit_sat;
  assign push_o.cmd.delta        = in_i.delta_ns;

endmodule

@@ hdl/tbpt_queue.sv @@
// ----------------------------------------------------------------------------
// tbpt_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module tbpt_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tbpt_pkg::push_t       push_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output tbpt_pkg::head_t       head_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tbpt_pkg::cmd_t    mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = rd_ptr_q + 1'b1;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.cmd;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_ptr_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CntW'(Depth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

@@ hdl/tbpt_back.sv @@
// ----------------------------------------------------------------------------
// tbpt_back
// Burst accounting pipeline: saturating add, log2, scaling, penalty update.
// ----------------------------------------------------------------------------
module tbpt_back #(
  parameter int unsigned MaxPenalty = 10239
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tbpt_pkg::cfg_t        cfg_i,
  input  tbpt_pkg::head_t       head_i,
  output logic                  pop_o,
  tbpt_out_if.source            out_o
);

  localparam int unsigned ScoreW = tbpt_pkg::ScoreW;
  localparam int unsigned DeltaW = tbpt_pkg::DeltaW;
  localparam int unsigned LeadW  = tbpt_pkg::LeadW;
  localparam int unsigned FracW  = tbpt_pkg::FracW;
  localparam int unsigned LogW   = tbpt_pkg::LogW;
  localparam int unsigned ProdW  = tbpt_pkg::ProdW;
  localparam int unsigned SclW   = ProdW - tbpt_pkg::ScaleShift;
  localparam logic [ScoreW-1:0] MaxPen   = ScoreW'(MaxPenalty);
  localparam logic [LeadW-1:0]  WordBits = LeadW'(DeltaW);

  function automatic logic [LeadW-1:0] lead_zeros(input logic [DeltaW-1:0] v);
    logic [2:0] grp;
    logic [2:0] pos;
    logic [7:0] sel;
    grp = '0;
    pos = '0;
    for (int i = 0; i < 8; i++) begin
      if (|v[i*8 +: 8]) grp = 3'(i);
    end
    sel = v[grp*8 +: 8];
    for (int j = 0; j < 8; j++) begin
      if (sel[j]) pos = 3'(j);
    end
    return {1'b0, ~grp, ~pos};
  endfunction

  logic adv;

  // stage 1: burst time
  logic                s1_valid_q;
  tbpt_pkg::tag_t      s1_tag_q;
  logic [DeltaW-1:0]   s1_burst_q;
  logic [DeltaW-1:0]   burst_q, burst_d;
  logic [DeltaW:0]     burst_sum;

  // stage 2: leading zeros
  logic                s2_valid_q;
  tbpt_pkg::tag_t      s2_tag_q;
  logic [DeltaW-1:0]   s2_val_q;
  logic                s2_zero_q;
  logic [LeadW-1:0]    s2_lead_q;

  // stage 3: log2 minus offset
  logic                s3_valid_q;
  tbpt_pkg::tag_t      s3_tag_q;
  logic [LogW-1:0]     s3_excess_q;
  logic [DeltaW-1:0]   s3_norm;
  logic [LogW-1:0]     s3_log;
  logic [LogW-1:0]     s3_tol;
  logic [LogW-1:0]     s3_excess_d;

  // stage 4: scale
  logic                s4_valid_q;
  tbpt_pkg::tag_t      s4_tag_q;
  logic [ProdW-1:0]    s4_prod_q;

  // update stage / output register
  logic                out_valid_q;
  logic [ScoreW-1:0]   curr_q, curr_d;
  logic [ScoreW-1:0]   prev_q, prev_d;
  logic [ScoreW-1:0]   eff_q, eff_d;
  logic [SclW-1:0]     scaled;
  logic [ScoreW-1:0]   score;
  logic [ScoreW-1:0]   blend;

  assign adv   = !out_valid_q || out_o.ready;
  assign pop_o = adv && head_i.valid;

  assign burst_sum = {1'b0, burst_q} + {1'b0, head_i.cmd.delta};

  always_comb begin
    burst_d = burst_q;
    case (head_i.cmd.tag.kind)
      tbpt_pkg::KIND_RUN:     burst_d = burst_sum[DeltaW] ? '1 : burst_sum[DeltaW-1:0];
      tbpt_pkg::KIND_RESTART: burst_d = '0;
      tbpt_pkg::KIND_FORK:    burst_d = '0;
      default:                burst_d = burst_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= '0;
    end else if (pop_o) begin
      burst_q <= burst_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= head_i.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  assign s3_norm     = s2_val_q << s2_lead_q[LeadW-2:0];
  assign s3_log      = s2_zero_q ? '0 :
                       {WordBits - s2_lead_q, s3_norm[DeltaW-2 -: FracW]};
  assign s3_tol      = {cfg_i.offset, {FracW{1'b0}}};
  assign s3_excess_d = (s3_log > s3_tol) ? (s3_log - s3_tol) : '0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tag_q    <= head_i.cmd.tag;
      s1_burst_q  <= burst_d;
      s2_tag_q    <= s1_tag_q;
      s2_val_q    <= s1_burst_q;
      s2_zero_q   <= (s1_burst_q == '0);
      s2_lead_q   <= lead_zeros(s1_burst_q);
      s3_tag_q    <= s2_tag_q;
      s3_excess_q <= s3_excess_d;
      s4_tag_q    <= s3_tag_q;
      s4_prod_q   <= ProdW'(s3_excess_q) * ProdW'(cfg_i.scale);
    end
  end

  assign scaled = s4_prod_q[ProdW-1:tbpt_pkg::ScaleShift];
  assign score  = (scaled > SclW'(MaxPen)) ? MaxPen : scaled[ScoreW-1:0];
  assign blend  = prev_q + ((curr_q - prev_q) >> cfg_i.smooth);

  always_comb begin
    curr_d = curr_q;
    prev_d = prev_q;
    eff_d  = eff_q;
    case (s4_tag_q.kind)
      tbpt_pkg::KIND_RUN: begin
        curr_d = score;
        if (score > prev_q) eff_d = s4_tag_q.kthread ? '0 : score;
      end
      tbpt_pkg::KIND_RESTART: begin
        prev_d = (curr_q >= prev_q) ? blend : curr_q;
        curr_d = '0;
        eff_d  = s4_tag_q.kthread ? '0 : prev_d;
      end
      tbpt_pkg::KIND_FORK: begin
        prev_d = (prev_q < s4_tag_q.inherit) ? s4_tag_q.inherit : prev_q;
        curr_d = '0;
        eff_d  = prev_d;
      end
      default: begin
        curr_d = curr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curr_q <= '0;
      prev_q <= '0;
      eff_q  <= '0;
    end else if (adv && s4_valid_q) begin
      curr_q <= curr_d;
      prev_q <= prev_d;
      eff_q  <= eff_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.penalty          = eff_q;
  assign out_o.current_penalty  = curr_q;
  assign out_o.previous_penalty = prev_q;

  a_score_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (curr_q <= MaxPen) && (prev_q <= MaxPen) && (eff_q <= MaxPen))
    else $error("penalty above limit");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s4_valid_q && s4_tag_q.kind == tbpt_pkg::KIND_RESTART) |=> (curr_q == '0))
    else $error("current penalty not cleared on restart");

  a_burst_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (head_i.cmd.tag.kind == tbpt_pkg::KIND_RESTART ||
               head_i.cmd.tag.kind == tbpt_pkg::KIND_FORK)) |=> (burst_q == '0))
    else $error("burst time not cleared");

endmodule

@@ hdl/task_burst_penalty_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// task_burst_penalty_tracker_unit
// Top level: configuration registers, front decoder, queue and back pipeline.
// ----------------------------------------------------------------------------
// Takes one accounting event per cycle while the output side is not stalled
// and returns one result per event, in order. A result passes one queue stage,
// then the burst add, the leading-zero count, the normalise and offset step,
// the multiply, and the penalty update that also forms the output register.
// The two-entry queue keeps the input taking up to two transfers while a
// result waits. Configuration writes are taken at any time but should only be
// made when no event is in flight.
module task_burst_penalty_tracker_unit #(
  parameter int unsigned MaxPenalty = 10239
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tbpt_in_if.sink                           in_i,
  tbpt_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [tbpt_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tbpt_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  tbpt_pkg::cfg_t  cfg_q, cfg_d;
  tbpt_pkg::push_t push;
  tbpt_pkg::head_t head;
  logic            full;
  logic            pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tbpt_pkg::CFG_ENABLE: cfg_d.enable = cfg_wdata_i[0];
        tbpt_pkg::CFG_SMOOTH: cfg_d.smooth = cfg_wdata_i[tbpt_pkg::SmoothW-1:0];
        tbpt_pkg::CFG_OFFSET: cfg_d.offset = cfg_wdata_i[tbpt_pkg::OffsetW-1:0];
        tbpt_pkg::CFG_SCALE:  cfg_d.scale  = cfg_wdata_i[tbpt_pkg::ScaleW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable <= 1'b1;
      cfg_q.smooth <= tbpt_pkg::SmoothW'(1);
      cfg_q.offset <= tbpt_pkg::OffsetW'(24);
      cfg_q.scale  <= tbpt_pkg::ScaleW'(1280);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tbpt_front #(
    .MaxPenalty (MaxPenalty)
  ) u_front (
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push)
  );

  tbpt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  tbpt_back #(
    .MaxPenalty (MaxPenalty)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
